@@ design/smbs_pkg.sv @@
package smbs_pkg;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_FIRST  = 2'd2,
        PH_SECOND = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_SEND = 2'd1,
        KIND_RECV = 2'd2,
        KIND_RSVD = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PER  = 2'd2;

    typedef struct packed {
        logic [1:0] spi_mode;
        logic       lsb_first;
        logic [7:0] half_period_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       mosi_level;
        logic       sclk_level;
    } res_t;

endpackage

@@ design/smbs_cfg_regs.sv @@
module smbs_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output smbs_pkg::cfg_t                    cfg
);

    logic [1:0] spi_mode_reg;
    logic       lsb_first_reg;
    logic [7:0] half_period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_mode_reg    <= 2'd0;
            lsb_first_reg   <= 1'b0;
            half_period_reg <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                smbs_pkg::CFG_SPI_MODE:  spi_mode_reg    <= cfg_data[1:0];
                smbs_pkg::CFG_LSB_FIRST: lsb_first_reg   <= cfg_data[0];
                smbs_pkg::CFG_HALF_PER:  half_period_reg <= cfg_data[7:0];
                default:                 ;
            endcase
        end
    end

    assign cfg.spi_mode          = spi_mode_reg;
    assign cfg.lsb_first         = lsb_first_reg;
    assign cfg.half_period_ticks = half_period_reg;

endmodule

@@ design/smbs_engine.sv @@
module smbs_engine #(
    parameter int BITS_PER_WORD = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [1:0]          kind,
    input  logic [7:0]          tx_byte,
    input  logic                miso_level,
    input  smbs_pkg::cfg_t      cfg,
    output smbs_pkg::res_t      res
);

    localparam int CW = $clog2(BITS_PER_WORD + 1);
    localparam int IW = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;

    smbs_pkg::phase_t           phase_reg, phase_next;
    logic [CW-1:0]              bit_reg, bit_next, bit_inc;
    logic [BITS_PER_WORD-1:0]   shift_reg, shift_next, tx_word;
    logic [7:0]                 tick_reg, tick_next, tick_inc, half;
    logic                       recv_reg, recv_next;
    logic                       sclk_reg, sclk_next;
    logic                       mosi_reg, mosi_next;
    logic                       cpol, cpha, enter_first, done, is_start;
    logic [7:0]                 rx;

    function automatic logic [IW-1:0] bit_sel(input logic [CW-1:0] n, input logic lsb);
        logic [IW-1:0] low;
        low = n[IW-1:0];
        return lsb ? low : (IW'(BITS_PER_WORD - 1) - low);
    endfunction

    assign cpol     = cfg.spi_mode[1];
    assign cpha     = cfg.spi_mode[0];
    assign half     = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
    assign tx_word  = BITS_PER_WORD'({{BITS_PER_WORD{1'b0}}, tx_byte});
    assign tick_inc = tick_reg + 8'd1;
    assign bit_inc  = bit_reg + CW'(1);
    assign is_start = (kind == smbs_pkg::KIND_SEND) || (kind == smbs_pkg::KIND_RECV);

    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        tick_next   = tick_reg;
        recv_next   = recv_reg;
        sclk_next   = sclk_reg;
        mosi_next   = mosi_reg;
        enter_first = 1'b0;
        done        = 1'b0;
        rx          = 8'd0;
        case (phase_reg)
            smbs_pkg::PH_IDLE:
            begin
                if (is_start)
                begin
                    recv_next  = (kind == smbs_pkg::KIND_RECV);
                    shift_next = recv_next ? '0 : tx_word;
                    bit_next   = '0;
                    tick_next  = 8'd0;
                    sclk_next  = cpol;
                    if (recv_next)
                    begin
                        mosi_next = 1'b1;
                    end
                    phase_next  = smbs_pkg::PH_SETTLE;
                    enter_first = (half <= 8'd1);
                end
            end
            default:
            begin
                tick_next = tick_inc;
                if (tick_inc >= half)
                begin
                    tick_next = 8'd0;
                    case (phase_reg)
                        smbs_pkg::PH_SETTLE:
                        begin
                            enter_first = 1'b1;
                        end
                        smbs_pkg::PH_FIRST:
                        begin
                            phase_next = smbs_pkg::PH_SECOND;
                            sclk_next  = cpol ^ cpha ^ 1'b1;
                            if (recv_reg)
                            begin
                                shift_next[bit_sel(bit_reg, cfg.lsb_first)] =
                                    shift_reg[bit_sel(bit_reg, cfg.lsb_first)] | miso_level;
                            end
                        end
                        default:
                        begin
                            bit_next = bit_inc;
                            if (bit_inc >= CW'(BITS_PER_WORD))
                            begin
                                phase_next = smbs_pkg::PH_IDLE;
                                sclk_next  = cpol;
                                done       = 1'b1;
                                if (recv_reg)
                                begin
                                    rx = 8'({8'd0, shift_reg});
                                end
                                bit_next = '0;
                            end
                            else
                            begin
                                enter_first = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase
        if (enter_first)
        begin
            phase_next = smbs_pkg::PH_FIRST;
            sclk_next  = cpol ^ cpha;
            mosi_next  = recv_next ? 1'b1 : shift_next[bit_sel(bit_next, cfg.lsb_first)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= smbs_pkg::PH_IDLE;
            bit_reg   <= '0;
            shift_reg <= '0;
            tick_reg  <= 8'd0;
            recv_reg  <= 1'b0;
            sclk_reg  <= 1'b0;
            mosi_reg  <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            recv_reg  <= recv_next;
            sclk_reg  <= sclk_next;
            mosi_reg  <= mosi_next;
        end
    end

    assign res.sclk_level = sclk_next;
    assign res.mosi_level = mosi_next;
    assign res.busy_res   = (phase_next != smbs_pkg::PH_IDLE);
    assign res.done_res   = done;
    assign res.rx_byte    = rx;

endmodule

@@ design/smbs_out_stage.sv @@
module smbs_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  smbs_pkg::res_t  res_in,
    output logic            out_valid,
    input  logic            out_ready,
    output smbs_pkg::res_t  res_out
);

    logic           valid_reg;
    smbs_pkg::res_t data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

@@ design/spi_master_byte_shifter_unit.sv @@
// Channel | Dir | Handshake        | Payload
// s       | in  | s_tvalid/tready  | tuser: kind; tdata: tx_byte, miso_level
// m       | out | m_tvalid/tready  | tdata: sclk, mosi, busy, done, rx_byte
// cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
//
// One request per cycle while s_tready is high; its result is registered when it is accepted.
// The tick update is one pass of the engine logic between state and output registers.
// Reset (rst_n low) idles the engine, sclk low, mosi high, config to defaults.
// A stalled output holds s_tready low only while the output register is full.
// cfg_ready is always high; writes to index 3 are dropped.
module spi_master_byte_shifter_unit #(
    parameter int BITS_PER_WORD = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [smbs_pkg::S_TDATA_W-1:0]      s_tdata,   // tx_byte[7:0], miso_level[8]
    input  logic [smbs_pkg::S_TUSER_W-1:0]      s_tuser,   // kind[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [smbs_pkg::M_TDATA_W-1:0]      m_tdata,   // sclk, mosi, busy, done, rx[11:4]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [smbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    smbs_pkg::cfg_t cfg;
    smbs_pkg::res_t res_now;
    smbs_pkg::res_t res_out;
    logic           step;

    assign step = s_tvalid && s_tready;

    smbs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smbs_engine #(
        .BITS_PER_WORD (BITS_PER_WORD)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .kind       (s_tuser[1:0]),
        .tx_byte    (s_tdata[7:0]),
        .miso_level (s_tdata[8]),
        .cfg        (cfg),
        .res        (res_now)
    );

    smbs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .res_in    (res_now),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (res_out)
    );

    assign m_tdata = {4'd0, res_out.rx_byte, res_out.done_res, res_out.busy_res,
                      res_out.mosi_level, res_out.sclk_level};

endmodule

@@ design/smbs_checker.sv @@
module smbs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [smbs_pkg::M_TDATA_W-1:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output dropped or changed while stalled");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) && m_tvalid && m_tready |=> !m_tvalid)
        else $error("result without request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done while still busy");

    a_rx_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:4] != 8'd0) |-> m_tdata[3])
        else $error("received byte outside done");

endmodule

bind spi_master_byte_shifter_unit smbs_checker u_smbs_checker (.*);
